@@ src/rtpb_pkg.sv @@
// Shared types, constants and register codes of the RTP/UDP/IPv4 header builder.
// Used by every module under src; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rtpb_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_RTP_BYTES   = 1328;
	localparam int DEF_TS_PACKET_BYTES = 188;

	// Lengths carried internally; 11 bits covers the largest IPv4 total length
	// over the whole parameter range (1472 + 28).
	localparam int LEN_W = 11;

	// RTP header size and the fixed IPv4/UDP header overheads.
	localparam int RTP_HDR_BYTES = 12;
	localparam int IP_UDP_BYTES  = 28;
	localparam int UDP_HDR_BYTES = 8;

	// Timestamp divider: one time tick group per RTP timestamp unit.
	localparam int STAMP_DIV    = 90000;
	localparam int REM_W        = 17;
	localparam int DIGIT_W      = 16;
	localparam int DIV_X_W      = REM_W + DIGIT_W;
	localparam int RECIP_SHIFT  = 34;
	localparam int RECIP_W      = 18;
	localparam logic [RECIP_W-1:0] STAMP_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / STAMP_DIV);
	localparam int PROD_W       = DIV_X_W + RECIP_W;

	// Fixed header fields.
	localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
	localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
	localparam logic [15:0] IP_TTL_PROTO   = 16'h0A11;
	localparam logic [7:0]  RTP_VERSION    = 8'h80;

	// Output word sequencing.
	localparam int          WORD_IDX_W = 3;
	localparam logic [WORD_IDX_W-1:0] WORD_LAST = 3'd6;
	localparam logic [3:0]  BYTES_FULL = 4'd8;
	localparam logic [3:0]  BYTES_TAIL = 4'd6;

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_MAC     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_MAC      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_IP       = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_IP      = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_PORT    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAM_SSRC  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_KIND = 4'd7;
	localparam logic [6:0] PAYLOAD_KIND_RESET = 7'd33;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration register set.
	typedef struct packed {
		logic [47:0] dest_mac;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] dest_ip;
		logic [15:0] src_port;
		logic [15:0] dest_port;
		logic [31:0] stream_ssrc;
		logic [6:0]  payload_kind;
	} cfg_t;

	// Per-request fields computed by the front.
	typedef struct packed {
		logic [LEN_W-1:0] ip_total;
		logic [LEN_W-1:0] udp_len;
		logic [15:0]      seq;
		logic [15:0]      ip_csum;
		logic [31:0]      stamp;
	} job_t;

endpackage

`default_nettype wire

@@ src/rtpb_front.sv @@
// Front end: accepts send requests, clamps the length, runs the timestamp
// divider and the IPv4 checksum, and pushes one job per request. Uses rtpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpb_front #(
	parameter int MAX_RTP_BYTES   = rtpb_pkg::DEF_MAX_RTP_BYTES,
	parameter int TS_PACKET_BYTES = rtpb_pkg::DEF_TS_PACKET_BYTES
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [10:0]          rtp_length,
	input  wire                  inject_packet,
	input  wire  [63:0]          time_now,
	input  rtpb_pkg::cfg_t       cfg,
	input  wire                  q_room,
	output logic                 q_push,
	output rtpb_pkg::job_t       q_data
);
	import rtpb_pkg::*;

	localparam logic [2:0] STEP_LAST = 3'd5;

	logic                   busy_q;
	logic [2:0]             step_q;
	logic [15:0]            seq_cnt_q;
	logic [LEN_W-1:0]       ip_total_q;
	logic [LEN_W-1:0]       udp_len_q;
	logic [15:0]            seq_q;
	logic [47:0]            time_lo_q;
	logic [REM_W-1:0]       rem_q;
	logic [DIV_X_W-1:0]     x_q;
	logic [PROD_W-1:0]      prod_q;
	logic [DIGIT_W-1:0]     quot_q;
	logic [17:0]            sum_a_q;
	logic [17:0]            sum_b_q;
	logic [18:0]            sum_q;
	logic [15:0]            csum_q;

	logic                   accept;
	logic                   finish;
	logic [LEN_W-1:0]       rlen_sat;
	logic [DIGIT_W-1:0]     digit;
	logic [DIV_X_W-1:0]     div_x;
	logic [DIGIT_W-1:0]     q_est;
	logic [DIV_X_W-1:0]     q_prod;
	logic [DIV_X_W-1:0]     part_rem;
	logic                   fix;
	logic [REM_W-1:0]       rem_next;
	logic [DIGIT_W-1:0]     q_digit;
	logic [16:0]            fold1;
	logic [15:0]            fold2;

	// Handshake: a new request is taken when idle or as the current job leaves.
	assign finish   = busy_q && (step_q == STEP_LAST) && q_room;
	assign in_ready = !busy_q || finish;
	assign accept   = in_valid && in_ready;

	// Length clamp; inject mode fixes the length at the RTP header plus one TS packet.
	always_comb begin
		priority if (inject_packet) begin
			rlen_sat = LEN_W'(RTP_HDR_BYTES + TS_PACKET_BYTES);
		end else if (LEN_W'(rtp_length) < LEN_W'(RTP_HDR_BYTES)) begin
			rlen_sat = LEN_W'(RTP_HDR_BYTES);
		end else if (LEN_W'(rtp_length) > LEN_W'(MAX_RTP_BYTES)) begin
			rlen_sat = LEN_W'(MAX_RTP_BYTES);
		end else begin
			rlen_sat = LEN_W'(rtp_length);
		end
	end

	// Digit fed to the divider in each multiply step.
	always_comb begin
		unique case (step_q[2:1])
			2'd0:    digit = time_lo_q[47:32];
			2'd1:    digit = time_lo_q[31:16];
			2'd2:    digit = time_lo_q[15:0];
			default: digit = '0;
		endcase
	end

	assign div_x = {rem_q, digit};

	// Correction step: estimate is the quotient or one below it.
	assign q_est    = prod_q[RECIP_SHIFT+DIGIT_W-1:RECIP_SHIFT];
	assign q_prod   = DIV_X_W'(q_est) * DIV_X_W'(STAMP_DIV);
	assign part_rem = x_q - q_prod;
	assign fix      = part_rem >= DIV_X_W'(STAMP_DIV);
	assign rem_next = fix ? REM_W'(part_rem - DIV_X_W'(STAMP_DIV)) : REM_W'(part_rem);
	assign q_digit  = q_est + DIGIT_W'(fix);

	// Checksum folding of the end-around carry.
	assign fold1 = 17'(sum_q[15:0]) + 17'(sum_q[18:16]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);

	// Job handed to the queue in the last divider step, once the queue has room.
	assign q_push = finish;
	always_comb begin
		q_data.ip_total = ip_total_q;
		q_data.udp_len  = udp_len_q;
		q_data.seq      = seq_q;
		q_data.ip_csum  = csum_q;
		q_data.stamp    = {quot_q, q_digit};
	end

	// Control: busy flag, step counter and running sequence number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= '0;
			seq_cnt_q <= '0;
		end else begin
			if (accept) begin
				busy_q    <= 1'b1;
				step_q    <= '0;
				seq_cnt_q <= seq_cnt_q + 16'd1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (busy_q && step_q != STEP_LAST) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// Request capture, divider and checksum datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			ip_total_q <= rlen_sat + LEN_W'(IP_UDP_BYTES);
			udp_len_q  <= rlen_sat + LEN_W'(UDP_HDR_BYTES);
			seq_q      <= seq_cnt_q;
			time_lo_q  <= time_now[47:0];
			rem_q      <= REM_W'(time_now[63:48]);
		end else if (busy_q && step_q != STEP_LAST) begin
			if (!step_q[0]) begin
				x_q    <= div_x;
				prod_q <= PROD_W'(div_x) * PROD_W'(STAMP_RECIP);
			end else begin
				rem_q  <= rem_next;
				quot_q <= q_digit;
			end
		end

		// Checksum runs alongside the first three divider steps.
		if (busy_q && step_q == 3'd0) begin
			sum_a_q <= 18'(ip_total_q) + 18'(seq_q + 16'd1) + 18'(IP_VER_IHL_TOS)
				+ 18'(IP_TTL_PROTO);
			sum_b_q <= 18'(cfg.src_ip[31:16]) + 18'(cfg.src_ip[15:0])
				+ 18'(cfg.dest_ip[31:16]) + 18'(cfg.dest_ip[15:0]);
		end
		if (busy_q && step_q == 3'd1) begin
			sum_q <= 19'(sum_a_q) + 19'(sum_b_q);
		end
		if (busy_q && step_q == 3'd2) begin
			csum_q <= ~fold2;
		end
	end

endmodule

`default_nettype wire

@@ src/rtpb_queue.sv @@
// Two-entry job queue between the front and the back of the header builder.
// Uses rtpb_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rtpb_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  rtpb_pkg::job_t   push_data,
	output logic             room,
	input  wire              pop,
	output logic             avail,
	output rtpb_pkg::job_t   pop_data
);
	import rtpb_pkg::*;

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign room     = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign avail    = count_q != '0;
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ src/rtpb_back.sv @@
// Back end: takes one job at a time and emits the seven header words through
// an output register. Uses rtpb_pkg for the job and configuration types.
`timescale 1ns / 1ps
`default_nettype none

module rtpb_back (
	input  wire              clk,
	input  wire              arst_n,
	input  rtpb_pkg::cfg_t   cfg,
	input  wire              q_avail,
	input  rtpb_pkg::job_t   q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [63:0]      header_word,
	output logic [3:0]       bytes_valid,
	output logic             last_word
);
	import rtpb_pkg::*;

	job_t                  job_q;
	logic                  job_valid_q;
	logic [WORD_IDX_W-1:0] word_q;
	logic                  out_valid_q;
	logic [63:0]           word_data_q;
	logic                  last_q;

	logic                  advance;
	logic                  job_done;
	logic [63:0]           word;
	logic [15:0]           ip_id;

	assign advance  = job_valid_q && (!out_valid_q || out_ready);
	assign job_done = advance && (word_q == WORD_LAST);
	assign q_pop    = q_avail && (!job_valid_q || job_done);
	assign ip_id    = job_q.seq + 16'd1;

	// Header word for the current position.
	always_comb begin
		unique case (word_q)
			3'd0: word = {cfg.dest_mac, cfg.src_mac[47:32]};
			3'd1: word = {cfg.src_mac[31:0], ETH_TYPE_IPV4, IP_VER_IHL_TOS};
			3'd2: word = {16'(job_q.ip_total), ip_id, 16'h0000, IP_TTL_PROTO};
			3'd3: word = {job_q.ip_csum, cfg.src_ip, cfg.dest_ip[31:16]};
			3'd4: word = {cfg.dest_ip[15:0], cfg.src_port, cfg.dest_port,
				16'(job_q.udp_len)};
			3'd5: word = {16'h0000, RTP_VERSION, 1'b0, cfg.payload_kind, job_q.seq,
				job_q.stamp[31:16]};
			3'd6: word = {job_q.stamp[15:0], cfg.stream_ssrc, 16'h0000};
			default: word = '0;
		endcase
	end

	// Job holding, word position and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			word_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (job_done) begin
				word_q      <= '0;
				job_valid_q <= q_avail;
			end else if (advance) begin
				word_q <= word_q + WORD_IDX_W'(1);
			end else if (!job_valid_q && q_avail) begin
				job_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
		end
		if (advance) begin
			word_data_q <= word;
			last_q      <= word_q == WORD_LAST;
		end
	end

	assign out_valid   = out_valid_q;
	assign header_word = word_data_q;
	assign last_word   = last_q;
	assign bytes_valid = last_q ? BYTES_TAIL : BYTES_FULL;

endmodule

`default_nettype wire

@@ src/rtp_udp_ipv4_header_builder.sv @@
// Top level of the RTP/UDP/IPv4/Ethernet header builder: configuration registers,
// front end, job queue and word serializer. Uses rtpb_pkg, rtpb_front, rtpb_queue, rtpb_back.
`timescale 1ns / 1ps
`default_nettype none

// Each send request (RTP length, inject flag, time count) yields the 54-byte
// Ethernet, IPv4, UDP and RTP header as seven 64-bit words, first byte in the
// top bits, 8 valid bytes on words one to six and 6 on the last. The front end
// finds the timestamp (time / 90000) with a three-digit divider that takes a
// multiply step and a correction step per 16-bit digit, while the IPv4 checksum
// is summed alongside. The back end emits one word per cycle while the receiver
// is ready, so the output word port sets the sustained request rate. A
// two-entry queue lets the front take new requests while earlier headers are
// still leaving. The user must see that configuration is written only while
// idle; the block does not enforce it. cfg_ready is always high and writes to
// unknown indexes are ignored.
module rtp_udp_ipv4_header_builder #(
	parameter int MAX_RTP_BYTES   = rtpb_pkg::DEF_MAX_RTP_BYTES,
	parameter int TS_PACKET_BYTES = rtpb_pkg::DEF_TS_PACKET_BYTES
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [10:0]                         rtp_length,
	input  wire                                 inject_packet,
	input  wire  [63:0]                         time_now,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [63:0]                         header_word,
	output logic [3:0]                          bytes_valid,
	output logic                                last_word,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [rtpb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [rtpb_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rtpb_pkg::*;

	cfg_t  cfg_q;
	job_t  push_data;
	job_t  pop_data;
	logic  q_room;
	logic  q_push;
	logic  q_avail;
	logic  q_pop;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_mac     <= '0;
			cfg_q.src_mac      <= '0;
			cfg_q.src_ip       <= '0;
			cfg_q.dest_ip      <= '0;
			cfg_q.src_port     <= '0;
			cfg_q.dest_port    <= '0;
			cfg_q.stream_ssrc  <= '0;
			cfg_q.payload_kind <= PAYLOAD_KIND_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEST_MAC:     cfg_q.dest_mac     <= cfg_data;
				CFG_SRC_MAC:      cfg_q.src_mac      <= cfg_data;
				CFG_SRC_IP:       cfg_q.src_ip       <= cfg_data[31:0];
				CFG_DEST_IP:      cfg_q.dest_ip      <= cfg_data[31:0];
				CFG_SRC_PORT:     cfg_q.src_port     <= cfg_data[15:0];
				CFG_DEST_PORT:    cfg_q.dest_port    <= cfg_data[15:0];
				CFG_STREAM_SSRC:  cfg_q.stream_ssrc  <= cfg_data[31:0];
				CFG_PAYLOAD_KIND: cfg_q.payload_kind <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Request intake, divider and checksum.
	rtpb_front #(
		.MAX_RTP_BYTES   (MAX_RTP_BYTES),
		.TS_PACKET_BYTES (TS_PACKET_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rtp_length    (rtp_length),
		.inject_packet (inject_packet),
		.time_now      (time_now),
		.cfg           (cfg_q),
		.q_room        (q_room),
		.q_push        (q_push),
		.q_data        (push_data)
	);

	// Job queue between the two halves.
	rtpb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.room      (q_room),
		.pop       (q_pop),
		.avail     (q_avail),
		.pop_data  (pop_data)
	);

	// Header word serializer.
	rtpb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_avail     (q_avail),
		.q_data      (pop_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.header_word (header_word),
		.bytes_valid (bytes_valid),
		.last_word   (last_word)
	);

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the RTP/UDP/IPv4 header builder: directed and random send requests,
// with every output word compared against a predicted seven-word header.
// Depends on rtpb_pkg and rtp_udp_ipv4_header_builder under src.
`timescale 1ns / 1ps

module tb_top;

	// Block parameters, passed explicitly so the prediction uses the same values.
	localparam int MAX_RTP = 1328;
	localparam int TS_BYTES = 188;

	// Fixed header contents and sizes.
	localparam int RTP_HEADER_BYTES = 12;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0] IPV4_VER_IHL = 8'h45;
	localparam logic [7:0] IPV4_TTL = 8'd10;
	localparam logic [7:0] IPPROTO_UDP = 8'h11;
	localparam logic [7:0] RTP_V2 = 8'h80;
	localparam logic [63:0] TICKS_PER_STAMP = 64'd90000;
	localparam logic [15:0] IP_UDP_OVERHEAD = 16'd28;
	localparam logic [15:0] UDP_OVERHEAD = 16'd8;
	localparam int WORDS_PER_HEADER = 7;
	localparam logic [3:0] FULL_WORD_BYTES = 4'd8;
	localparam logic [3:0] TAIL_WORD_BYTES = 4'd6;

	// Register indexes past the end of the register list.
	localparam logic [rtpb_pkg::CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 4'd8;
	localparam logic [rtpb_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LAST = 4'd15;

	localparam int RUN_LIMIT_NS = 5000000;
	localparam int DRAIN_CYCLES = 16;

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		DRAIN_FREE,
		DRAIN_COIN,
		DRAIN_SPARSE,
		DRAIN_MOSTLY
	} drain_mode_t;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
	} header_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [10:0] rtp_length;
	logic inject_packet;
	logic [63:0] time_now;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [63:0] header_word;
	logic [3:0] bytes_valid;
	logic last_word;
	logic cfg_valid;
	logic cfg_ready;
	logic [rtpb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rtpb_pkg::CFG_DATA_W-1:0] cfg_data;

	// Predicted register contents and running sequence number.
	logic [47:0] dest_mac_q = '0;
	logic [47:0] src_mac_q = '0;
	logic [31:0] src_ip_q = '0;
	logic [31:0] dest_ip_q = '0;
	logic [15:0] src_port_q = '0;
	logic [15:0] dest_port_q = '0;
	logic [31:0] ssrc_q = '0;
	logic [6:0] payload_kind_q = 7'd33;
	logic [15:0] seq_count = '0;

	header_word_t pending_words[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	drain_mode_t drain_mode = DRAIN_FREE;

	rtp_udp_ipv4_header_builder #(
		.MAX_RTP_BYTES(MAX_RTP),
		.TS_PACKET_BYTES(TS_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rtp_length(rtp_length),
		.inject_packet(inject_packet),
		.time_now(time_now),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.header_word(header_word),
		.bytes_valid(bytes_valid),
		.last_word(last_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Build the 54-byte header of one request, advance the sequence number and queue its words.
	function automatic void predict_header(input logic [10:0] len, input logic inj,
			input logic [63:0] t);
		logic [10:0] rtp_bytes;
		logic [15:0] ip_total;
		logic [15:0] udp_total;
		logic [15:0] old_seq;
		logic [15:0] new_seq;
		logic [31:0] acc;
		logic [15:0] csum;
		logic [63:0] quotient;
		logic [447:0] header_bits;
		header_word_t entry;

		if (inj)
			rtp_bytes = 11'(RTP_HEADER_BYTES + TS_BYTES);
		else if (len < RTP_HEADER_BYTES)
			rtp_bytes = 11'(RTP_HEADER_BYTES);
		else if (len > MAX_RTP)
			rtp_bytes = 11'(MAX_RTP);
		else
			rtp_bytes = len;
		ip_total = 16'(rtp_bytes) + IP_UDP_OVERHEAD;
		udp_total = 16'(rtp_bytes) + UDP_OVERHEAD;

		old_seq = seq_count;
		new_seq = seq_count + 16'd1;
		seq_count = new_seq;

		// Ones' complement sum over the IPv4 header with the checksum field at zero.
		acc = 32'({IPV4_VER_IHL, 8'h00}) + 32'(ip_total) + 32'(new_seq)
			+ 32'({IPV4_TTL, IPPROTO_UDP}) + 32'(src_ip_q[31:16]) + 32'(src_ip_q[15:0])
			+ 32'(dest_ip_q[31:16]) + 32'(dest_ip_q[15:0]);
		acc = 32'(acc[15:0]) + 32'(acc[31:16]);
		acc = 32'(acc[15:0]) + 32'(acc[31:16]);
		csum = ~acc[15:0];

		quotient = t / TICKS_PER_STAMP;

		header_bits = {dest_mac_q, src_mac_q, ETHERTYPE_IPV4,
			IPV4_VER_IHL, 8'h00, ip_total, new_seq, 16'h0000,
			IPV4_TTL, IPPROTO_UDP, csum, src_ip_q, dest_ip_q,
			src_port_q, dest_port_q, udp_total, 16'h0000,
			RTP_V2, 1'b0, payload_kind_q, old_seq, quotient[31:0], ssrc_q,
			16'h0000};

		for (int w = 0; w < WORDS_PER_HEADER; w++) begin
			entry.word = header_bits[447 - 64 * w -: 64];
			entry.last = (w == WORDS_PER_HEADER - 1);
			entry.nbytes = entry.last ? TAIL_WORD_BYTES : FULL_WORD_BYTES;
			pending_words.push_back(entry);
		end
	endfunction

	// Present one request and hold it until accepted. Valid stays high for a following request.
	task automatic send_request(input logic [10:0] len, input logic inj, input logic [63:0] t);
		in_valid <= 1'b1;
		rtp_length <= len;
		inject_packet <= inj;
		time_now <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_header(len, inj, t);
	endtask

	// Drop the request valid for a gap of the given number of cycles.
	task automatic pause_requests(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	// Write one register and mirror it in the predicted register set.
	task automatic write_reg(input logic [rtpb_pkg::CFG_IDX_W-1:0] idx, input logic [47:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			rtpb_pkg::CFG_DEST_MAC: dest_mac_q = data;
			rtpb_pkg::CFG_SRC_MAC: src_mac_q = data;
			rtpb_pkg::CFG_SRC_IP: src_ip_q = data[31:0];
			rtpb_pkg::CFG_DEST_IP: dest_ip_q = data[31:0];
			rtpb_pkg::CFG_SRC_PORT: src_port_q = data[15:0];
			rtpb_pkg::CFG_DEST_PORT: dest_port_q = data[15:0];
			rtpb_pkg::CFG_STREAM_SSRC: ssrc_q = data[31:0];
			rtpb_pkg::CFG_PAYLOAD_KIND: payload_kind_q = data[6:0];
			default: ;
		endcase
	endtask

	task automatic end_reg_writes();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every predicted word has come out.
	task automatic wait_idle();
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_all_regs(input logic [47:0] data);
		write_reg(rtpb_pkg::CFG_DEST_MAC, data);
		write_reg(rtpb_pkg::CFG_SRC_MAC, data);
		write_reg(rtpb_pkg::CFG_SRC_IP, data);
		write_reg(rtpb_pkg::CFG_DEST_IP, data);
		write_reg(rtpb_pkg::CFG_SRC_PORT, data);
		write_reg(rtpb_pkg::CFG_DEST_PORT, data);
		write_reg(rtpb_pkg::CFG_STREAM_SSRC, data);
		write_reg(rtpb_pkg::CFG_PAYLOAD_KIND, data);
	endtask

	// Random request: mostly in-range lengths, some below and above the limits, some injects.
	task automatic send_random_request();
		logic [10:0] len;
		logic [63:0] t;
		int pick;

		pick = $urandom_range(0, 99);
		if (pick < 70)
			len = 11'($urandom_range(RTP_HEADER_BYTES, MAX_RTP));
		else if (pick < 85)
			len = 11'($urandom_range(0, RTP_HEADER_BYTES - 1));
		else
			len = 11'($urandom_range(MAX_RTP + 1, 2047));
		if ($urandom_range(0, 3) == 0)
			t = 64'($urandom_range(0, 400000));
		else
			t = {$urandom, $urandom};
		send_request(len, ($urandom_range(0, 3) == 0), t);
	endtask

	// Requests at the reset register values.
	task automatic test_reset_values();
		send_request(11'd100, 1'b0, 64'd0);
		send_request(11'd500, 1'b1, 64'd90000);
		pause_requests(3);
	endtask

	// Length saturation at both ends, inject mode and timestamp truncation.
	task automatic test_length_limits();
		send_request(11'd0, 1'b0, 64'd89999);
		send_request(11'd11, 1'b0, 64'd90001);
		send_request(11'd12, 1'b0, '1);
		send_request(11'd13, 1'b0, 64'h0001_5F90_0000_0000);
		send_request(11'd1327, 1'b0, 64'h0001_5F8F_FFFF_FFFF);
		pause_requests(2);
		send_request(11'd1328, 1'b0, 64'h8000_0000_0000_0000);
		send_request(11'd1329, 1'b0, 64'h5555_5555_5555_5555);
		send_request(11'd2047, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(11'd0, 1'b1, 64'd1);
		send_request(11'd2047, 1'b1, 64'd180000);
		send_request(11'd700, 1'b1, 64'hFFFF_FFFF);
		pause_requests(4);
	endtask

	// Registers at all ones (wider data than the narrow registers hold) and at zero;
	// writes to indexes past the list must leave everything unchanged.
	task automatic test_register_extremes();
		wait_idle();
		write_all_regs('1);
		write_reg(CFG_UNUSED_FIRST, '0);
		write_reg(CFG_UNUSED_LAST, '0);
		end_reg_writes();
		send_request(11'd2047, 1'b0, '1);
		send_request(11'd0, 1'b1, 64'd0);
		send_request(11'd12, 1'b0, 64'd12345678);
		pause_requests(1);
		wait_idle();
		write_all_regs('0);
		write_reg(CFG_UNUSED_LAST, '1);
		end_reg_writes();
		send_request(11'd1328, 1'b0, '1);
		send_request(11'd200, 1'b1, 64'd0);
		pause_requests(2);
	endtask

	// Random register settings, each followed by bursty random traffic.
	task automatic test_random_traffic();
		int sent;
		int burst;
		int k;

		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			write_reg(rtpb_pkg::CFG_DEST_MAC, 48'({$urandom, $urandom}));
			write_reg(rtpb_pkg::CFG_SRC_MAC, 48'({$urandom, $urandom}));
			write_reg(rtpb_pkg::CFG_SRC_IP, 48'({$urandom, $urandom}));
			write_reg(rtpb_pkg::CFG_DEST_IP, 48'({$urandom, $urandom}));
			write_reg(rtpb_pkg::CFG_SRC_PORT, 48'({$urandom, $urandom}));
			write_reg(rtpb_pkg::CFG_DEST_PORT, 48'({$urandom, $urandom}));
			write_reg(rtpb_pkg::CFG_STREAM_SSRC, 48'({$urandom, $urandom}));
			write_reg(rtpb_pkg::CFG_PAYLOAD_KIND, 48'({$urandom, $urandom}));
			write_reg(4'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
				48'({$urandom, $urandom}));
			end_reg_writes();

			sent = 0;
			while (sent < 40) begin
				burst = $urandom_range(1, 12);
				for (k = 0; k < burst && sent < 40; k++) begin
					send_random_request();
					sent++;
				end
				if ($urandom_range(0, 4) == 0)
					pause_requests($urandom_range(10, 25));
				else
					pause_requests($urandom_range(1, 8));
			end
		end
	endtask

	// Receiver: ready follows a stall pattern that is re-picked at random, keyed to the cycle counter.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 48 == 0)
			drain_mode <= drain_mode_t'($urandom_range(0, 3));
		case (drain_mode)
			DRAIN_FREE: out_ready <= 1'b1;
			DRAIN_COIN: out_ready <= ($urandom_range(0, 1) == 1);
			DRAIN_SPARSE: out_ready <= (cycle_count % 5 == 0);
			default: out_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Compare each accepted word with the oldest prediction.
	always @(posedge clk) begin
		header_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("header_word %h arrived with no request outstanding", header_word);
				mismatch_count++;
			end else begin
				want = pending_words.pop_front();
				if (header_word !== want.word) begin
					$error("header_word: expected %h, got %h", want.word, header_word);
					mismatch_count++;
				end
				if (bytes_valid !== want.nbytes) begin
					$error("bytes_valid: expected %0d, got %0d", want.nbytes, bytes_valid);
					mismatch_count++;
				end
				if (last_word !== want.last) begin
					$error("last_word: expected %b, got %b", want.last, last_word);
					mismatch_count++;
				end
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rtp_length <= '0;
		inject_packet <= 1'b0;
		time_now <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_length_limits();
		test_register_extremes();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#RUN_LIMIT_NS;
		$display("Mismatches found");
		$finish;
	end

endmodule
